>>> src/hlcm_pkg.sv
package hlcm_pkg;

	// field widths of the channels
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned HYPER_W  = 32;

	// default width of the tick arithmetic
	localparam int unsigned TICK_WIDTH_DEF = 32;

endpackage

>>> src/hlcm_if.sv
// request channel carrying one task period
interface hlcm_in_if;
	logic                             valid;
	logic                             ready;
	logic [hlcm_pkg::PERIOD_W-1:0]    period;
	logic                             first;

	modport source (output valid, output period, output first, input ready);
	modport sink   (input valid, input period, input first, output ready);
endinterface

// result channel carrying the running hyperperiod
interface hlcm_out_if;
	logic                             valid;
	logic                             ready;
	logic [hlcm_pkg::HYPER_W-1:0]     hyperperiod;
	logic                             overflow;

	modport source (output valid, output hyperperiod, output overflow, input ready);
	modport sink   (input valid, input hyperperiod, input overflow, output ready);
endinterface

>>> src/hyperperiod_lcm_accumulator.sv
// Hyperperiod accumulator: running least common multiple of task periods.
// in_ch (valid/ready) takes one request: a period and a first mark. A first
// request loads the period and clears the sticky overflow flag; any other
// request folds the period in as lcm(H, p) = (H / gcd(H, p)) * p.
// out_ch (valid/ready) returns one result per request: the running value
// (saturated to all ones on overflow) and the sticky overflow flag.
// First, zero and post-overflow requests skip the arithmetic. A full
// lcm runs on one shared adder/subtractor: a binary gcd of up to about
// 4*TICK_WIDTH steps counting swaps, up to TICK_WIDTH doubling steps, a
// restoring divide of TICK_WIDTH steps and a shift-add multiply of up to
// TICK_WIDTH steps, cut short on overflow.
// One request is in flight at a time; in_ch.ready is high only when idle.
// A finished result waits in the output register; while out_ch is stalled
// the next request may still be taken and worked on, and its result is
// held back until the output register is free.
// Reset sets the running value to 1, clears the overflow flag and drops
// out_ch.valid.
module hyperperiod_lcm_accumulator #(
	parameter int unsigned TICK_WIDTH = hlcm_pkg::TICK_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	hlcm_in_if.sink           in_ch,
	hlcm_out_if.source        out_ch
);

	localparam int unsigned AW = TICK_WIDTH + 2;
	localparam int unsigned CW = $clog2(TICK_WIDTH + 1);
	localparam int unsigned KW = $clog2(TICK_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_SHIFT,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [TICK_WIDTH-1:0]   run_q;
	logic                    ovf_q;
	logic [TICK_WIDTH-1:0]   p_q;
	logic [TICK_WIDTH-1:0]   a_q;
	logic [TICK_WIDTH-1:0]   b_q;
	logic [KW-1:0]           k_q;
	logic [CW-1:0]           cnt_q;
	logic [TICK_WIDTH-1:0]   rem_q;
	logic [TICK_WIDTH-1:0]   quo_q;
	logic [TICK_WIDTH-1:0]   acc_q;
	logic                    out_valid_q;
	logic [hlcm_pkg::HYPER_W-1:0] out_hyper_q;
	logic                    out_ovf_q;

	logic [TICK_WIDTH+hlcm_pkg::PERIOD_W-1:0] p_ext;
	logic [TICK_WIDTH-1:0]   p_in;
	logic [TICK_WIDTH+hlcm_pkg::HYPER_W-1:0]  run_ext;
	logic                    in_acc;
	logic [TICK_WIDTH:0]     div_try;
	logic [AW-1:0]           op_a;
	logic [AW-1:0]           op_b;
	logic                    op_sub;
	logic [AW-1:0]           alu_res;
	logic                    alu_neg;

	// period trimmed or widened to the tick width
	assign p_ext   = {{TICK_WIDTH{1'b0}}, in_ch.period};
	assign p_in    = p_ext[TICK_WIDTH-1:0];
	assign run_ext = {{hlcm_pkg::HYPER_W{1'b0}}, run_q};

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// partial remainder with the next dividend bit shifted in
	assign div_try = {rem_q, quo_q[TICK_WIDTH-1]};

	// operand select for the shared adder/subtractor
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			ST_GCD: begin
				op_a   = {2'b00, a_q};
				op_b   = {2'b00, b_q};
				op_sub = 1'b1;
			end
			ST_DIV: begin
				op_a   = {1'b0, div_try};
				op_b   = {2'b00, a_q};
				op_sub = 1'b1;
			end
			ST_MUL: begin
				op_a = {1'b0, acc_q, 1'b0};
				op_b = quo_q[TICK_WIDTH-1] ? {2'b00, p_q} : '0;
			end
			default: begin
				op_a   = '0;
				op_b   = '0;
				op_sub = 1'b0;
			end
		endcase
	end

	// shared adder/subtractor
	assign alu_res = op_a + (op_sub ? ~op_b : op_b) + {{(AW-1){1'b0}}, op_sub};
	assign alu_neg = alu_res[AW-1];

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= {{(TICK_WIDTH-1){1'b0}}, 1'b1};
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken by the receiver, unless a new one is handed over
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						p_q <= p_in;
						a_q <= run_q;
						b_q <= p_in;
						k_q <= '0;
						if (in_ch.first) begin
							run_q   <= p_in;
							ovf_q   <= 1'b0;
							state_q <= ST_DONE;
						end else if (ovf_q) begin
							state_q <= ST_DONE;
						end else if (run_q == '0 || p_in == '0) begin
							run_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_GCD;
						end
					end
				end

				// binary gcd, common factors of two counted in k
				ST_GCD: begin
					if (alu_res == '0) begin
						state_q <= ST_SHIFT;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (alu_neg) begin
						a_q <= b_q;
						b_q <= a_q;
					end else begin
						a_q <= alu_res[TICK_WIDTH:1];
					end
				end

				// restore the factors of two into the gcd
				ST_SHIFT: begin
					if (k_q == '0) begin
						rem_q   <= '0;
						quo_q   <= run_q;
						cnt_q   <= CW'(TICK_WIDTH);
						state_q <= ST_DIV;
					end else begin
						a_q <= a_q << 1;
						k_q <= k_q - KW'(1);
					end
				end

				// restoring divide of the running value by the gcd
				ST_DIV: begin
					if (alu_neg) begin
						rem_q <= div_try[TICK_WIDTH-1:0];
					end else begin
						rem_q <= alu_res[TICK_WIDTH-1:0];
					end
					quo_q <= {quo_q[TICK_WIDTH-2:0], !alu_neg};
					if (cnt_q == CW'(1)) begin
						acc_q   <= '0;
						cnt_q   <= CW'(TICK_WIDTH);
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end

				// shift-add multiply by the period, msb first, stop on overflow
				ST_MUL: begin
					if (alu_res[AW-1:TICK_WIDTH] != 2'b00) begin
						run_q   <= '1;
						ovf_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						acc_q <= alu_res[TICK_WIDTH-1:0];
						quo_q <= quo_q << 1;
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							run_q   <= alu_res[TICK_WIDTH-1:0];
							state_q <= ST_DONE;
						end
					end
				end

				// hand the result over once the output register is free
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_hyper_q <= run_ext[hlcm_pkg::HYPER_W-1:0];
						out_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.hyperperiod = out_hyper_q;
	assign out_ch.overflow    = out_ovf_q;

endmodule

>>> src/hlcm_checker.sv
module hlcm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [hlcm_pkg::HYPER_W-1:0]       out_hyperperiod,
	input logic                               out_overflow
);

	// a pending result stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
	else $error("result dropped while stalled");

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_hyperperiod) && $stable(out_overflow))
	else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("request taken while busy");

	// an overflowed result is saturated, never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_overflow |-> out_hyperperiod != '0)
	else $error("overflow flagged with zero hyperperiod");

endmodule

bind hyperperiod_lcm_accumulator hlcm_checker u_hlcm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_hyperperiod (out_ch.hyperperiod),
	.out_overflow    (out_ch.overflow)
);
